// File: rtl/qcr_pkg.sv
// ----------------------------------------------------------------------------
// qcr_pkg
// Shared types and constants for the quad collision resolve unit.
// ----------------------------------------------------------------------------
`default_nettype none
package qcr_pkg;
  localparam int CornersDefault  = 4;
  localparam int FracBitsDefault = 16;
  localparam int CoordW          = 32;

  typedef enum logic [1:0] {
    OP_LOAD_MOVING   = 2'd0,
    OP_LOAD_OBSTACLE = 2'd1,
    OP_CHECK         = 2'd2,
    OP_NONE          = 2'd3
  } opcode_t;
endpackage
`default_nettype wire

// File: rtl/quad_collision_resolve_unit.sv
// ----------------------------------------------------------------------------
// quad_collision_resolve_unit
// Diagonal-against-edge collision test and centre push-back, sequenced
// over one shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// Loads give no result. A check runs each diagonal-edge pair through S_M0 to
// S_M5, S_TEST and S_NEXT; a hit adds FRAC_BITS divider steps and the push
// states S_PX and S_PY. After CORNERS*CORNERS pairs, S_DONE loads the result.
// Input is taken again the cycle after a check ends; a result held by out_stall
// holds only the S_DONE state of the next check. One shared 33x33 multiplier.
// Synchronous active-high reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module quad_collision_resolve_unit import qcr_pkg::*; #(
  parameter int CORNERS   = CornersDefault,
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               opcode,
  input  wire logic [1:0]               corner_index,
  input  wire logic signed [CoordW-1:0] coord_x,
  input  wire logic signed [CoordW-1:0] coord_y,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          overlap,
  output logic signed [CoordW-1:0]      new_x,
  output logic signed [CoordW-1:0]      new_y
);
  localparam int IW = $clog2(CORNERS);
  localparam int DW = CoordW + 1;
  localparam int PW = 2 * DW;
  localparam int WW = PW + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = CoordW + 8;
  localparam int KW = $clog2(FRAC_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_TEST, S_DIV,
    S_PX, S_PY, S_NEXT, S_DONE
  } state_t;

  logic signed [CoordW-1:0] mx [CORNERS];
  logic signed [CoordW-1:0] my [CORNERS];
  logic signed [CoordW-1:0] ox [CORNERS];
  logic signed [CoordW-1:0] oy [CORNERS];

  state_t state;
  logic signed [CoordW-1:0] cx, cy;
  logic [IW-1:0] di, ej;
  logic signed [WW-1:0] det, n1, n2, acc;
  logic [QW-1:0] q;
  logic [KW-1:0] k;
  logic hit;
  logic signed [SW-1:0] push_x, push_y, tot_x, tot_y;

  logic [IW-1:0] en;
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [WW-1:0] n1s;
  logic signed [WW-1:0] det_a, n1_a, n2_a;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [DW-1:0] wgt;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SW'(signed'(33'sh0_7FFF_FFFF))) return 32'sh7FFF_FFFF;
    else if (v < -SW'(signed'(33'sh0_8000_0000))) return 32'sh8000_0000;
    else return v[CoordW-1:0];
  endfunction

  assign en = (ej == IW'(CORNERS - 1)) ? '0 : ej + 1'b1;
  assign wgt = DW'((QW+1)'(1) << FRAC_BITS) - DW'(q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_M0: begin
        ma = DW'(ox[en]) - DW'(ox[ej]);
        mb = DW'(cy) - DW'(my[di]);
      end
      S_M1: begin
        ma = DW'(cx) - DW'(mx[di]);
        mb = DW'(oy[en]) - DW'(oy[ej]);
      end
      S_M2: begin
        ma = DW'(oy[ej]) - DW'(oy[en]);
        mb = DW'(cx) - DW'(ox[ej]);
      end
      S_M3: begin
        ma = DW'(ox[en]) - DW'(ox[ej]);
        mb = DW'(cy) - DW'(oy[ej]);
      end
      S_M4: begin
        ma = DW'(cy) - DW'(my[di]);
        mb = DW'(cx) - DW'(ox[ej]);
      end
      S_M5: begin
        ma = DW'(mx[di]) - DW'(cx);
        mb = DW'(cy) - DW'(oy[ej]);
      end
      S_PX: begin
        ma = wgt;
        mb = DW'(mx[di]) - DW'(cx);
      end
      S_PY: begin
        ma = wgt;
        mb = DW'(my[di]) - DW'(cy);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod  = ma * mb;
  assign n1s   = n1 <<< 1;
  assign det_a = det[WW-1] ? -det : det;
  assign n1_a  = det[WW-1] ? -n1 : n1;
  assign n2_a  = det[WW-1] ? -n2 : n2;
  assign sum_x = tot_x + push_x;
  assign sum_y = tot_y + push_y;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (opcode == OP_LOAD_MOVING && 32'(corner_index) < CORNERS) begin
              mx[IW'(corner_index)] <= coord_x;
              my[IW'(corner_index)] <= coord_y;
            end else if (opcode == OP_LOAD_OBSTACLE && 32'(corner_index) < CORNERS) begin
              ox[IW'(corner_index)] <= coord_x;
              oy[IW'(corner_index)] <= coord_y;
            end else if (opcode == OP_CHECK) begin
              cx <= coord_x;
              cy <= coord_y;
              di <= '0;
              ej <= '0;
              hit <= 1'b0;
              push_x <= '0;
              push_y <= '0;
              tot_x <= '0;
              tot_y <= '0;
              state <= S_M0;
            end
          end
        end
        S_M0: begin
          acc <= WW'(prod);
          state <= S_M1;
        end
        S_M1: begin
          det <= acc - WW'(prod);
          state <= S_M2;
        end
        S_M2: begin
          acc <= WW'(prod);
          state <= S_M3;
        end
        S_M3: begin
          n1 <= acc + WW'(prod);
          state <= S_M4;
        end
        S_M4: begin
          acc <= WW'(prod);
          state <= S_M5;
        end
        S_M5: begin
          n2 <= acc + WW'(prod);
          state <= S_TEST;
        end
        S_TEST: begin
          det <= det_a;
          n1  <= n1_a;
          q   <= '0;
          k   <= '0;
          if (det == '0 || n1_a < 0 || n1_a >= det_a || n2_a < 0 || n2_a >= det_a)
            state <= S_NEXT;
          else
            state <= S_DIV;
        end
        S_DIV: begin
          if (n1s >= det) begin
            n1 <= n1s - det;
            q  <= {q[QW-2:0], 1'b1};
          end else begin
            n1 <= n1s;
            q  <= {q[QW-2:0], 1'b0};
          end
          k <= k + 1'b1;
          if (k == KW'(FRAC_BITS - 1)) state <= S_PX;
        end
        S_PX: begin
          push_x <= push_x + SW'(prod >>> FRAC_BITS);
          state <= S_PY;
        end
        S_PY: begin
          push_y <= push_y + SW'(prod >>> FRAC_BITS);
          hit <= 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (ej == IW'(CORNERS - 1)) begin
            ej <= '0;
            tot_x <= sum_x;
            tot_y <= sum_y;
            push_x <= '0;
            push_y <= '0;
            if (di == IW'(CORNERS - 1)) state <= S_DONE;
            else begin
              di <= di + 1'b1;
              state <= S_M0;
            end
          end else begin
            ej <= en;
            state <= S_M0;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            overlap <= hit;
            new_x <= sat(SW'(cx) - tot_x);
            new_y <= sat(SW'(cy) - tot_y);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/qcr_checker.sv
// ----------------------------------------------------------------------------
// qcr_checker
// Port-level checks for the quad collision resolve unit.
// ----------------------------------------------------------------------------
`default_nettype none
module qcr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        overlap,
  input wire logic [31:0] new_x,
  input wire logic [31:0] new_y
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_x) && $stable(new_y)
      && $stable(overlap))
    else $error("result changed while stalled");
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("reset state wrong");
endmodule

bind quad_collision_resolve_unit qcr_checker u_qcr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .overlap(overlap),
  .new_x(new_x), .new_y(new_y)
);
`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad collision resolve unit. Corners of the
// moving and obstacle boxes are loaded, then checks are sent with a centre.
// A local predictor computes the overlap flag and the pushed-back centre.
// Each result is compared in order with the oldest prediction. Idle and
// stall patterns run in several phases, and one long receiver hold-off is
// included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top import qcr_pkg::*;;

  localparam int NCORNER = 4;
  localparam int FBITS   = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } centre_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_NONE;
  logic [1:0] corner_index = 2'd0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic overlap;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;

  quad_collision_resolve_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .corner_index(corner_index), .coord_x(coord_x),
    .coord_y(coord_y), .out_valid(out_valid), .out_stall(out_stall),
    .overlap(overlap), .new_x(new_x), .new_y(new_y)
  );

  always #5 clk = ~clk;

  longint mov_x[NCORNER], mov_y[NCORNER], obs_x[NCORNER], obs_y[NCORNER];
  centre_t pending_centres[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  function automatic longint floor_q(longint v);
    if (v >= 0) begin
      return v / (longint'(1) << FBITS);
    end
    return -((-v + (longint'(1) << FBITS) - 1) / (longint'(1) << FBITS));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic centre_t resolve_centre(longint x, longint y);
    centre_t r;
    longint tot_x, tot_y, push_x, push_y, dx, dy, sxv, syv, exv, eyv, wgt;
    logic signed [127:0] det, n1, n2, rem;
    longint q;
    int n;
    tot_x = 0;
    tot_y = 0;
    r.hit = 1'b0;
    for (int i = 0; i < NCORNER; i++) begin
      dx = mov_x[i];
      dy = mov_y[i];
      push_x = 0;
      push_y = 0;
      for (int j = 0; j < NCORNER; j++) begin
        n = (j + 1) % NCORNER;
        sxv = obs_x[j];
        syv = obs_y[j];
        exv = obs_x[n];
        eyv = obs_y[n];
        det = 128'(exv - sxv) * 128'(y - dy) - 128'(x - dx) * 128'(eyv - syv);
        n1 = 128'(syv - eyv) * 128'(x - sxv) + 128'(exv - sxv) * 128'(y - syv);
        n2 = 128'(y - dy) * 128'(x - sxv) + 128'(dx - x) * 128'(y - syv);
        if (det == 0) continue;
        if (det < 0) begin
          det = -det;
          n1 = -n1;
          n2 = -n2;
        end
        if (n1 < 0 || n1 >= det || n2 < 0 || n2 >= det) continue;
        rem = n1 <<< FBITS;
        q = longint'(rem / det);
        wgt = (longint'(1) << FBITS) - q;
        push_x += floor_q(wgt * (dx - x));
        push_y += floor_q(wgt * (dy - y));
        r.hit = 1'b1;
      end
      tot_x += push_x;
      tot_y += push_y;
    end
    r.cx = 32'(clamp32(x - tot_x));
    r.cy = 32'(clamp32(y - tot_y));
    return r;
  endfunction

  task automatic send_item(input opcode_t op, input logic [1:0] idx,
                           input logic signed [31:0] x, input logic signed [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    corner_index <= idx;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (in_stall);
    case (op)
      OP_LOAD_MOVING: begin
        mov_x[idx] = x;
        mov_y[idx] = y;
      end
      OP_LOAD_OBSTACLE: begin
        obs_x[idx] = x;
        obs_y[idx] = y;
      end
      OP_CHECK: pending_centres.push_back(resolve_centre(x, y));
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_centres.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // transfer checker and receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_centres.size() == 0) begin
        $display("%0t unexpected result overlap=%0b x=%0d y=%0d", $time,
                 overlap, new_x, new_y);
        errors++;
      end else begin
        centre_t e;
        e = pending_centres.pop_front();
        if (e.hit !== overlap) begin
          $display("%0t overlap exp %0b got %0b", $time, e.hit, overlap);
          errors++;
        end
        if (e.cx !== new_x) begin
          $display("%0t new_x exp %0d got %0d", $time, e.cx, new_x);
          errors++;
        end
        if (e.cy !== new_y) begin
          $display("%0t new_y exp %0d got %0d", $time, e.cy, new_y);
          errors++;
        end
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic load_boxes(int mode);
    for (int i = 0; i < NCORNER; i++) begin
      send_item(OP_LOAD_MOVING, 2'(i), rand_coord(mode), rand_coord(mode));
      send_item(OP_LOAD_OBSTACLE, 2'(i), rand_coord(mode), rand_coord(mode));
    end
  endtask

  // overlapping unit squares and field extremes
  task automatic test_directed;
    logic signed [31:0] one;
    one = 32'sh0001_0000;
    send_item(OP_LOAD_MOVING, 2'd0, -one, -one);
    send_item(OP_LOAD_MOVING, 2'd1, one, -one);
    send_item(OP_LOAD_MOVING, 2'd2, one, one);
    send_item(OP_LOAD_MOVING, 2'd3, -one, one);
    send_item(OP_LOAD_OBSTACLE, 2'd0, 0, -2 * one);
    send_item(OP_LOAD_OBSTACLE, 2'd1, 2 * one, -2 * one);
    send_item(OP_LOAD_OBSTACLE, 2'd2, 2 * one, 2 * one);
    send_item(OP_LOAD_OBSTACLE, 2'd3, 0, 2 * one);
    send_item(OP_CHECK, 2'd0, 0, 0);
    send_item(OP_CHECK, 2'd3, 10 * one, 10 * one);
    send_item(OP_NONE, 2'd1, 32'sh7fff_ffff, -32'sh8000_0000);
    send_item(OP_CHECK, 2'd1, 32'sh7fff_ffff, -32'sh8000_0000);
    send_item(OP_CHECK, 2'd2, -32'sh8000_0000, 32'sh7fff_ffff);
    // a zero-length edge gives a zero determinant
    send_item(OP_LOAD_OBSTACLE, 2'd0, 0, 0);
    send_item(OP_LOAD_OBSTACLE, 2'd1, 0, 0);
    send_item(OP_CHECK, 2'd0, one, 0);
    send_item(OP_LOAD_MOVING, 2'd2, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(OP_LOAD_OBSTACLE, 2'd2, -32'sh8000_0000, -32'sh8000_0000);
    send_item(OP_CHECK, 2'd0, -32'sh8000_0000, 32'sh7fff_ffff);
    send_item(OP_CHECK, 2'd0, 0, 0);
    drain();
  endtask

  task automatic test_random(int count, int idle, int stall);
    int mode;
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(2);
      case ($urandom_range(9))
        0: load_boxes(mode);
        1: send_item(opcode_t'($urandom_range(1)), 2'($urandom),
                     rand_coord(mode), rand_coord(mode));
        2: send_item(OP_NONE, 2'($urandom), $urandom, $urandom);
        default: send_item(OP_CHECK, 2'($urandom), rand_coord(mode),
                           rand_coord(mode));
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 12; n++) begin
        send_item(OP_CHECK, 2'($urandom), rand_coord(2), rand_coord(2));
      end
    join
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(320, 0, 0);
    test_random(190, 69, 0);
    test_random(190, 0, 69);
    test_random(190, 10, 10);
    test_backpressure();
    test_random(180, 0, 0);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
